// ===== src/per_source_connection_priority_macros.svh =====
// Assertion macros shared by the checker
`ifndef PER_SOURCE_CONNECTION_PRIORITY_MACROS_SVH
`define PER_SOURCE_CONNECTION_PRIORITY_MACROS_SVH
// Check that a condition implies a consequence in the same cycle
`define PSCP_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle
`define PSCP_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ===== src/pscp_pkg.sv =====
// ----------------------------------------------------------------------------
// pscp_pkg
// Shared types and codes for the per-source connection priority block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pscp_pkg;
    localparam logic [1:0] ACT_CONNECT = 2'd0;
    localparam logic [1:0] ACT_CLOSE   = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [1:0] ST_FIFO_FULL  = 2'd2;
    localparam logic [0:0] REG_WINDOW    = 1'd0;
    localparam logic [0:0] REG_THRESHOLD = 1'd1;

    // search request travelling down the cell row
    typedef struct packed {
        logic        valid;
        logic [63:0] prefix;
    } t_search;

    // per-cell update command, broadcast from the controller
    typedef struct packed {
        logic inc;
        logic dec;
        logic ins;
    } t_cmd;
endpackage

// ===== src/per_source_connection_priority.sv =====
// Busy is high while a connect or tick runs; a close is answered from idle.
// A tick reads and checks the FIFO head, searching once per retired record.
// One transaction at a time. The search walks the cell row one cell a cycle.
// Reset (synchronous, active low) empties the table and FIFO; registers
// return to window 60, threshold 8. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// per_source_connection_priority
// Per-prefix connection counter with visit FIFO and timed expiry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module per_source_connection_priority #(
    parameter int TABLE_ENTRIES = 64,
    parameter int VISIT_DEPTH   = 256,
    parameter int COUNT_BITS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [63:0]        i_source_prefix,
    input  logic [31:0]        i_time_stamp,
    output logic               o_strobe,
    output logic signed [16:0] o_priority_res,
    output logic [8:0]         o_expired_count,
    output logic [1:0]         o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:2]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int TW = $clog2(TABLE_ENTRIES);
    localparam int VW = $clog2(VISIT_DEPTH);
    localparam int SW = $clog2(TABLE_ENTRIES + 4);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]  r_state;
    logic [15:0] r_window, r_thresh;
    logic [63:0] r_pfx;
    logic [31:0] r_stamp;
    logic [SW-1:0] r_step;
    logic        r_tick;
    logic [8:0]  r_exp;
    logic        r_hit;
    logic [TW-1:0] r_hidx, r_fidx;
    logic        r_fok;
    logic [COUNT_BITS-1:0] r_prior;

    // visit FIFO memory
    logic [63:0] r_vp [VISIT_DEPTH];
    logic [31:0] r_vd [VISIT_DEPTH];
    logic [63:0] r_rp;
    logic [31:0] r_rd;
    logic [VW-1:0] r_head, r_tail;
    logic [VW:0]   r_fill;

    // cell row
    pscp_pkg::t_search w_s [TABLE_ENTRIES+1];
    logic w_hit [TABLE_ENTRIES+1];
    logic w_free [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] w_match, w_ff, w_sel;
    logic [COUNT_BITS-1:0] w_cnt [TABLE_ENTRIES];
    pscp_pkg::t_cmd w_cmd;
    logic [TW-1:0] w_cidx;

    assign w_hit[0]  = 1'b0;
    assign w_free[0] = 1'b0;
    assign w_s[0] = '{valid: (r_state == S_SRCH) && (r_step == '0), prefix: r_pfx};

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        assign w_sel[g] = (w_cidx == TW'(g));
        pscp_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_search(w_s[g]), .i_hit_in(w_hit[g]), .i_free_in(w_free[g]),
            .i_cmd(w_cmd), .i_sel(w_sel[g]), .i_ins_prefix(r_pfx),
            .o_search(w_s[g+1]), .o_hit_out(w_hit[g+1]), .o_free_out(w_free[g+1]),
            .o_match(w_match[g]), .o_free_first(w_ff[g]), .o_count(w_cnt[g])
        );
    end

    // capture hit and first free slot as the search passes
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE || r_state == S_CHK) begin
            r_hit <= 1'b0;
            r_fok <= 1'b0;
        end else begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                if (w_match[k]) begin
                    r_hit <= 1'b1; r_hidx <= TW'(k); r_prior <= w_cnt[k];
                end
                if (w_ff[k]) begin
                    r_fok <= 1'b1; r_fidx <= TW'(k);
                end
            end
        end
    end

    logic search_end;
    assign search_end = (r_state == S_SRCH) && (r_step == SW'(TABLE_ENTRIES + 1));
    logic [32:0] w_lim;
    assign w_lim = {1'b0, r_rd} + 33'(r_window);
    logic w_expire;
    assign w_expire = (r_fill != '0) && (w_lim < {1'b0, r_stamp});

    always_comb begin
        w_cmd  = '0;
        w_cidx = r_hit ? r_hidx : r_fidx;
        if (search_end && !r_tick) begin
            w_cmd.inc = r_hit;
            w_cmd.ins = !r_hit && r_fok;
        end else if (search_end) begin
            w_cmd.dec = r_hit;
        end
    end

    logic [16:0] w_mag;
    assign w_mag = (33'(r_prior) > 33'd65535) ? 17'd65535 : 17'(r_prior);
    assign pready = 1'b1;
    assign busy   = (r_state != S_IDLE);
    assign prdata = (paddr[2] == pscp_pkg::REG_THRESHOLD) ? {16'd0, r_thresh}
                                                         : {16'd0, r_window};

    always_ff @(posedge i_clk) begin
        r_rp <= r_vp[r_head];
        r_rd <= r_vd[r_head];
        if (start && !busy && i_action == pscp_pkg::ACT_CLOSE &&
            r_fill <= (VW+1)'(VISIT_DEPTH - 1)) begin
            r_vp[r_tail] <= i_source_prefix;
            r_vd[r_tail] <= i_time_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_pfx <= i_source_prefix; r_stamp <= i_time_stamp;
        end else if (r_state == S_CHK && w_expire) begin
            r_pfx <= r_rp;
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_window <= 16'd60;
            r_thresh <= 16'd8;
            r_head <= '0; r_tail <= '0; r_fill <= '0;
            o_strobe <= 1'b0;
            r_step <= '0; r_tick <= 1'b0; r_exp <= '0;
        end else begin
            o_strobe <= 1'b0;
            if (psel && penable && pwrite) begin
                if (paddr[2] == pscp_pkg::REG_WINDOW) r_window <= pwdata[15:0];
                else r_thresh <= pwdata[15:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_step <= '0; r_exp <= '0;
                        r_tick <= (i_action == pscp_pkg::ACT_TICK);
                        case (i_action)
                            pscp_pkg::ACT_CONNECT: r_state <= S_SRCH;
                            pscp_pkg::ACT_TICK:    r_state <= S_RD;
                            default: begin
                                o_strobe <= 1'b1;
                                o_priority_res <= '0; o_expired_count <= '0;
                                o_status <= pscp_pkg::ST_OK;
                                if (i_action == pscp_pkg::ACT_CLOSE) begin
                                    if (r_fill == (VW+1)'(VISIT_DEPTH))
                                        o_status <= pscp_pkg::ST_FIFO_FULL;
                                    else begin
                                        r_tail <= (r_tail == VW'(VISIT_DEPTH-1)) ? '0 : r_tail + 1'b1;
                                        r_fill <= r_fill + 1'b1;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_SRCH: begin
                    r_step <= r_step + 1'b1;
                    if (search_end) begin
                        r_step <= '0;
                        if (r_tick) r_state <= S_RD;
                        else begin
                            o_strobe <= 1'b1;
                            o_expired_count <= '0;
                            o_status <= (r_hit || r_fok) ? pscp_pkg::ST_OK
                                                         : pscp_pkg::ST_TABLE_FULL;
                            o_priority_res <= (r_hit && 33'(r_prior) >= 33'(r_thresh))
                                              ? -$signed(w_mag) : '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (w_expire) begin
                        r_head <= (r_head == VW'(VISIT_DEPTH-1)) ? '0 : r_head + 1'b1;
                        r_fill <= r_fill - 1'b1;
                        r_exp  <= r_exp + 1'b1;
                        r_state <= S_SRCH;
                    end else r_state <= S_DONE;
                end
                S_DONE: begin
                    o_strobe <= 1'b1;
                    o_priority_res <= '0; o_expired_count <= r_exp;
                    o_status <= pscp_pkg::ST_OK;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/pscp_cell.sv =====
// ----------------------------------------------------------------------------
// pscp_cell
// One table entry: holds a prefix and count, compares a passing search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pscp_cell #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pscp_pkg::t_search     i_search,
    input  logic                  i_hit_in,
    input  logic                  i_free_in,
    input  pscp_pkg::t_cmd        i_cmd,
    input  logic                  i_sel,
    input  logic [63:0]           i_ins_prefix,
    output pscp_pkg::t_search     o_search,
    output logic                  o_hit_out,
    output logic                  o_free_out,
    output logic                  o_match,
    output logic                  o_free_first,
    output logic [COUNT_BITS-1:0] o_count
);
    logic                  r_valid;
    logic [63:0]           r_prefix;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_sv;
    logic [63:0]           r_sp;

    assign o_match      = r_sv && r_valid && (r_prefix == r_sp);
    assign o_free_first = r_sv && !r_valid && !i_free_in;
    assign o_hit_out    = i_hit_in | o_match;
    assign o_free_out   = i_free_in | (r_sv && !r_valid);
    assign o_search     = '{valid: r_sv, prefix: r_sp};
    assign o_count      = r_count;

    always_ff @(posedge i_clk) begin
        // advance the search one cell a cycle
        r_sp <= i_search.prefix;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sv    <= 1'b0;
        end else begin
            r_sv <= i_search.valid;
            if (i_sel && i_cmd.ins) begin
                r_valid  <= 1'b1;
                r_prefix <= i_ins_prefix;
                r_count  <= COUNT_BITS'(1);
            end else if (i_sel && i_cmd.inc) begin
                if (r_count != {COUNT_BITS{1'b1}}) r_count <= r_count + 1'b1;
            end else if (i_sel && i_cmd.dec) begin
                if (r_count <= COUNT_BITS'(1)) r_valid <= 1'b0;
                else r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ===== src/pscp_checker.sv =====
// ----------------------------------------------------------------------------
// pscp_checker
// Port-level checks on the command and result handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "per_source_connection_priority_macros.svh"
module pscp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               busy,
    input logic               o_strobe,
    input logic signed [16:0] o_priority_res,
    input logic [1:0]         o_status
);
    // a busy spell ends only with a strobed result
    `PSCP_ASSERT_NXT(a_busy_release, i_clk, i_rst_n, busy, busy || o_strobe)
    `PSCP_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)
    `PSCP_ASSERT_IMP(a_prio_sign, i_clk, i_rst_n, o_strobe, o_priority_res <= 0)
    `PSCP_ASSERT_IMP(a_full_prio, i_clk, i_rst_n,
        o_strobe && o_status != pscp_pkg::ST_OK, o_priority_res == 0)
endmodule

bind per_source_connection_priority pscp_checker u_pscp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .busy(busy),
    .o_strobe(o_strobe), .o_priority_res(o_priority_res), .o_status(o_status)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-source connection priority testbench
// Drives connect, close and tick commands through the start/busy handshake,
// predicts results from a behavioural model of the count table and visit FIFO
// or takes a typed answer, and compares each strobed result with the oldest one.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TABLE_ENTRIES = 64;
    localparam int VISIT_DEPTH   = 256;
    localparam int COUNT_MAX     = 65535;
    // action code that the block answers with an all-zero result
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [16:0] prio;
        logic [8:0]         expired;
        logic [1:0]         status;
    } t_answer;

    // directed stimulus row; keep the typed answer only where it is obvious
    typedef struct {
        logic [1:0]  act;
        logic [63:0] pfx;
        logic [31:0] stamp;
        bit          typed;
        t_answer     answer;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_action;
    logic [63:0]        i_source_prefix;
    logic [31:0]        i_time_stamp;
    logic               o_strobe;
    logic signed [16:0] o_priority_res;
    logic [8:0]         o_expired_count;
    logic [1:0]         o_status;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:2]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    per_source_connection_priority DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_source_prefix (i_source_prefix),
        .i_time_stamp    (i_time_stamp),
        .o_strobe        (o_strobe),
        .o_priority_res  (o_priority_res),
        .o_expired_count (o_expired_count),
        .o_status        (o_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // model of the block: count table, visit FIFO and the two registers
    bit          tbl_used [TABLE_ENTRIES];
    logic [63:0] tbl_pfx  [TABLE_ENTRIES];
    int unsigned tbl_cnt  [TABLE_ENTRIES];
    logic [63:0] vq_pfx   [$];
    logic [31:0] vq_dep   [$];
    logic [15:0] window_s;
    logic [15:0] threshold;

    t_answer     pending_answers [$];
    int          mismatches;
    bit          no_idle;
    logic [63:0] pool [16];
    logic [31:0] now_s;

    // ------------------------------------------------------------------------
    // Clock and a generous overall limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic int lookup_prefix(input logic [63:0] pfx);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_used[i] && tbl_pfx[i] == pfx)
                return i;
        return -1;
    endfunction

    // Work out the answer to one command and advance the model state.
    function automatic t_answer predict_priority(input logic [1:0] act,
                                                 input logic [63:0] pfx,
                                                 input logic [31:0] stamp);
        t_answer     a;
        int          idx;
        int unsigned prior;
        int unsigned retired;
        a = '0;
        prior = 0;
        retired = 0;
        if (act == pscp_pkg::ACT_CONNECT) begin
            idx = lookup_prefix(pfx);
            if (idx >= 0) begin
                prior = tbl_cnt[idx];
                if (prior < COUNT_MAX)
                    tbl_cnt[idx] = prior + 1;
            end else begin
                for (int i = 0; i < TABLE_ENTRIES && idx < 0; i++)
                    if (!tbl_used[i])
                        idx = i;
                if (idx < 0) begin
                    a.status = pscp_pkg::ST_TABLE_FULL;
                end else begin
                    tbl_used[idx] = 1'b1;
                    tbl_pfx[idx]  = pfx;
                    tbl_cnt[idx]  = 1;
                end
            end
            if (a.status == pscp_pkg::ST_OK && prior >= threshold)
                a.prio = -$signed({1'b0, prior[15:0]});
        end else if (act == pscp_pkg::ACT_CLOSE) begin
            if (vq_pfx.size() >= VISIT_DEPTH) begin
                a.status = pscp_pkg::ST_FIFO_FULL;
            end else begin
                vq_pfx.push_back(pfx);
                vq_dep.push_back(stamp);
            end
        end else if (act == pscp_pkg::ACT_TICK) begin
            // retire only when departure + window lies strictly before now
            while (vq_dep.size() > 0 &&
                   ({1'b0, vq_dep[0]} + {17'b0, window_s}) < {1'b0, stamp}) begin
                idx = lookup_prefix(vq_pfx[0]);
                void'(vq_dep.pop_front());
                void'(vq_pfx.pop_front());
                retired++;
                if (idx >= 0) begin
                    if (tbl_cnt[idx] <= 1)
                        tbl_used[idx] = 1'b0;
                    else
                        tbl_cnt[idx]--;
                end
            end
            a.expired = retired[8:0];
        end
        return a;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking: the receiver cannot stall, so look at every strobe
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result", {o_priority_res, o_expired_count,
                                o_status}, '0);
            end else begin
                if (o_priority_res !== pending_answers[0].prio)
                    report_mismatch("priority_res", o_priority_res,
                                    pending_answers[0].prio);
                if (o_expired_count !== pending_answers[0].expired)
                    report_mismatch("expired_count", o_expired_count,
                                    pending_answers[0].expired);
                if (o_status !== pending_answers[0].status)
                    report_mismatch("status", o_status, pending_answers[0].status);
                void'(pending_answers.pop_front());
            end
        end
    end

    // Send one command; hold start high across back-to-back transactions.
    task automatic send_command(input logic [1:0] act, input logic [63:0] pfx,
                                input logic [31:0] stamp, input bit typed,
                                input t_answer answer);
        int      gap;
        t_answer predicted;
        gap = (!no_idle && $urandom_range(0, 99) < 8) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_action        <= act;
        i_source_prefix <= pfx;
        i_time_stamp    <= stamp;
        do @(posedge i_clk); while (busy);
        predicted = predict_priority(act, pfx, stamp);
        pending_answers.push_back(typed ? answer : predicted);
    endtask

    task automatic send_predicted(input logic [1:0] act, input logic [63:0] pfx,
                                  input logic [31:0] stamp);
        send_command(act, pfx, stamp, 1'b0, '0);
    endtask

    // Drain, write both registers through the APB port, then read them back.
    task automatic set_registers(input logic [15:0] win, input logic [15:0] thr);
        start <= 1'b0;
        while (pending_answers.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        for (int r = 0; r < 2; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= (r == 0) ? pscp_pkg::REG_WINDOW : pscp_pkg::REG_THRESHOLD;
            pwdata  <= {16'h0, (r == 0) ? win : thr};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        for (int r = 0; r < 2; r++) begin
            paddr <= (r == 0) ? pscp_pkg::REG_WINDOW : pscp_pkg::REG_THRESHOLD;
            @(posedge i_clk);
            if (prdata !== {16'h0, (r == 0) ? win : thr})
                report_mismatch("prdata", prdata, {16'h0, (r == 0) ? win : thr});
        end
        window_s  = win;
        threshold = thr;
    endtask

    // Random traffic: mostly a small pool of prefixes so counts build up.
    task automatic random_traffic(input int n);
        int          roll;
        logic [63:0] pfx;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            pfx  = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                : pool[$urandom_range(0, 15)];
            now_s = now_s + $urandom_range(0, 3);
            if (roll < 45)
                send_predicted(pscp_pkg::ACT_CONNECT, pfx, $urandom);
            else if (roll < 80)
                send_predicted(pscp_pkg::ACT_CLOSE, pfx, now_s - $urandom_range(0, 2));
            else if (roll < 97)
                send_predicted(pscp_pkg::ACT_TICK, pfx,
                               now_s + window_s * $urandom_range(0, 1));
            else
                send_predicted(ACT_UNUSED, pfx, $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_row rows [$];
        t_row row;
        mismatches = 0;
        no_idle    = 1'b0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_action   = pscp_pkg::ACT_CONNECT;
        i_source_prefix = '0;
        i_time_stamp    = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = pscp_pkg::REG_WINDOW;
        pwdata = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_used[i] = 1'b0; tbl_pfx[i] = '0; tbl_cnt[i] = 0;
        end
        window_s  = 16'd60;
        threshold = 16'd8;
        for (int i = 0; i < 16; i++)
            pool[i] = {$urandom, $urandom};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, reset register values (window 60, threshold 8)
        rows.push_back('{pscp_pkg::ACT_TICK, 64'h0, 32'd0, 1'b1,
                         '{17'sd0, 9'd0, pscp_pkg::ST_OK}});
        rows.push_back('{ACT_UNUSED, '1, '1, 1'b1, '{17'sd0, 9'd0, pscp_pkg::ST_OK}});
        rows.push_back('{pscp_pkg::ACT_CONNECT, 64'h0, 32'd0, 1'b1,
                         '{17'sd0, 9'd0, pscp_pkg::ST_OK}});
        rows.push_back('{pscp_pkg::ACT_CONNECT, '1, '1, 1'b1,
                         '{17'sd0, 9'd0, pscp_pkg::ST_OK}});
        rows.push_back('{pscp_pkg::ACT_CLOSE, 64'h0, 32'd0, 1'b1,
                         '{17'sd0, 9'd0, pscp_pkg::ST_OK}});
        // close for a prefix that was never connected: retired, no entry touched
        rows.push_back('{pscp_pkg::ACT_CLOSE, 64'hABC, 32'd5, 1'b1,
                         '{17'sd0, 9'd0, pscp_pkg::ST_OK}});
        // departure + window equal to now: nothing retires yet
        rows.push_back('{pscp_pkg::ACT_TICK, 64'h0, 32'd60, 1'b1,
                         '{17'sd0, 9'd0, pscp_pkg::ST_OK}});
        rows.push_back('{pscp_pkg::ACT_TICK, 64'h0, 32'd61, 1'b1,
                         '{17'sd0, 9'd1, pscp_pkg::ST_OK}});
        rows.push_back('{pscp_pkg::ACT_TICK, 64'h0, '1, 1'b1,
                         '{17'sd0, 9'd1, pscp_pkg::ST_OK}});
        // top departure time: the sum must not wrap past zero
        rows.push_back('{pscp_pkg::ACT_CLOSE, '1, '1, 1'b1,
                         '{17'sd0, 9'd0, pscp_pkg::ST_OK}});
        rows.push_back('{pscp_pkg::ACT_TICK, '1, '1, 1'b1,
                         '{17'sd0, 9'd0, pscp_pkg::ST_OK}});
        for (int i = 0; i < 11; i++) begin
            row = '{pscp_pkg::ACT_CONNECT, 64'h5555_AAAA_0F0F_F0F0, 32'h0, 1'b0, '0};
            rows.push_back(row);
        end
        foreach (rows[i])
            send_command(rows[i].act, rows[i].pfx, rows[i].stamp, rows[i].typed,
                         rows[i].answer);

        // random phases across register settings, extremes included
        now_s = $urandom;
        set_registers(16'd0, 16'd0);
        random_traffic(250);
        set_registers(16'hFFFF, 16'hFFFF);
        no_idle = 1'b1;
        random_traffic(250);
        no_idle = 1'b0;
        set_registers(16'd10, 16'd3);
        now_s = 32'hFFFF_FF00;
        random_traffic(300);
        set_registers(16'd1, 16'd1);
        random_traffic(250);

        // flood the visit FIFO past its depth, then drain it in one tick
        set_registers(16'd60, 16'd8);
        for (int i = 0; i < VISIT_DEPTH + 4; i++)
            send_predicted(pscp_pkg::ACT_CLOSE, pool[i % 16], now_s);
        send_predicted(pscp_pkg::ACT_TICK, '0, now_s + 32'd61);
        now_s = now_s + 32'd61;

        // fill the count table with fresh prefixes until it overflows
        set_registers(16'd5, 16'd2);
        for (int i = 0; i < TABLE_ENTRIES + 6; i++)
            send_predicted(pscp_pkg::ACT_CONNECT, {$urandom, $urandom}, '0);
        random_traffic(250);

        start <= 1'b0;
        while (pending_answers.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
